// ===== rtl/core/vsn_pkg.sv =====
`default_nettype none
package vsn_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SCALE_X = 2'd0;
    localparam logic [1:0] REG_SCALE_Y = 2'd1;
    localparam logic [1:0] REG_SCALE_Z = 2'd2;

    localparam logic [23:0] SCALE_ONE = 24'd65536;

    localparam int FRONT_STAGES = 7;
    localparam int SQRT_STAGES  = 31;  // one root bit per stage
    localparam int DIV_STAGES   = 15;  // one quotient bit per stage

    // Words that ride along with the normal math
    typedef struct packed {
        logic [2:0][31:0] pos;  // scaled, saturated position, x in [0]
        logic [2:0]       neg;  // sign of each scaled normal axis
        logic             deg;  // scaled normal is all zero
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [2:0][29:0] a;    // normalized magnitudes
        logic [61:0]      s;    // sum of squares
    } t_root_in;

    typedef struct packed {
        t_side            side;
        logic [2:0][29:0] a;
        logic [30:0]      len;  // floor(sqrt(s))
    } t_div_in;

    typedef struct packed {
        t_side            side;
        logic [2:0][14:0] q;    // unsigned unit normal magnitudes
    } t_div_out;

endpackage
`default_nettype wire

// ===== rtl/core/vsn_front.sv =====
`default_nettype none
module vsn_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic [2:0][31:0]      i_pos,
    input  wire logic [2:0][15:0]      i_nrm,
    input  wire logic [2:0][23:0]      i_scale,
    output logic                       o_vld,
    output vsn_pkg::t_root_in          o_data
);
    import vsn_pkg::*;

    logic [FRONT_STAGES-1:0] r_vld;

    logic signed [55:0] r_pp [3];
    logic signed [39:0] r_mn [3];
    t_side              r_side2, r_side3, r_side4, r_side5, r_side6, r_side7;
    logic [38:0]        r_a2 [3];
    logic [38:0]        r_a3 [3];
    logic [38:0]        r_mx3;
    logic [38:0]        r_a4 [3];
    logic [5:0]         r_p4;
    logic [29:0]        r_a5 [3];
    logic [29:0]        r_a6 [3];
    logic [59:0]        r_sq6 [3];
    logic [29:0]        r_a7 [3];
    logic [61:0]        r_s7;

    logic signed [55:0] n_pp [3];
    logic signed [39:0] n_mn [3];
    t_side              n_side2;
    logic [38:0]        n_a2 [3];
    logic [38:0]        n_mx3;
    logic [5:0]         n_p4;
    logic [29:0]        n_a5 [3];

    always_comb begin
        logic signed [31:0] pv;
        logic signed [15:0] nv;
        logic signed [23:0] sv;
        logic signed [55:0] t;
        logic signed [39:0] rr;
        logic signed [39:0] mm;
        logic [38:0]        sh;
        n_side2 = '0;
        for (int i = 0; i < 3; i++) begin
            pv = i_pos[i];
            nv = i_nrm[i];
            sv = i_scale[i];
            n_pp[i] = pv * sv;
            n_mn[i] = nv * sv;
            // round to nearest, ties up, then saturate
            t  = r_pp[i] + 56'sd32768;
            rr = t[55:16];
            if (rr > 40'sd2147483647) begin
                n_side2.pos[i] = 32'h7fff_ffff;
            end else if (rr < -40'sd2147483648) begin
                n_side2.pos[i] = 32'h8000_0000;
            end else begin
                n_side2.pos[i] = rr[31:0];
            end
            mm = r_mn[i][39] ? -r_mn[i] : r_mn[i];
            n_a2[i] = mm[38:0];
            n_side2.neg[i] = r_mn[i][39];
            sh = (r_p4 > 6'd29) ? (r_a4[i] >> (r_p4 - 6'd29)) : (r_a4[i] << (6'd29 - r_p4));
            n_a5[i] = sh[29:0];
        end
        n_mx3 = r_a2[0];
        if (r_a2[1] > n_mx3) begin
            n_mx3 = r_a2[1];
        end
        if (r_a2[2] > n_mx3) begin
            n_mx3 = r_a2[2];
        end
        n_p4 = '0;
        for (int b = 0; b < 39; b++) begin
            if (r_mx3[b]) begin
                n_p4 = 6'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pp[i]  <= n_pp[i];
                r_mn[i]  <= n_mn[i];
                r_a2[i]  <= n_a2[i];
                r_a3[i]  <= r_a2[i];
                r_a4[i]  <= r_a3[i];
                r_a5[i]  <= n_a5[i];
                r_a6[i]  <= r_a5[i];
                r_sq6[i] <= r_a5[i] * r_a5[i];
                r_a7[i]  <= r_a6[i];
            end
            r_side2     <= n_side2;
            r_side3     <= '{pos: r_side2.pos, neg: r_side2.neg, deg: (n_mx3 == '0)};
            r_mx3       <= n_mx3;
            r_side4     <= r_side3;
            r_p4        <= n_p4;
            r_side5     <= r_side4;
            r_side6     <= r_side5;
            r_side7     <= r_side6;
            r_s7        <= {2'b00, r_sq6[0]} + {2'b00, r_sq6[1]} + {2'b00, r_sq6[2]};
        end
    end

    assign o_vld       = r_vld[FRONT_STAGES-1];
    assign o_data.side = r_side7;
    assign o_data.a    = {r_a7[2], r_a7[1], r_a7[0]};
    assign o_data.s    = r_s7;

endmodule
`default_nettype wire

// ===== rtl/core/vsn_sqrt.sv =====
`default_nettype none
module vsn_sqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire vsn_pkg::t_root_in  i_data,
    output logic                    o_vld,
    output vsn_pkg::t_div_in        o_data
);
    import vsn_pkg::*;

    logic [SQRT_STAGES-1:0] r_vld;
    logic [31:0]            r_rem  [SQRT_STAGES];
    logic [30:0]            r_root [SQRT_STAGES];
    t_root_in               r_pl   [SQRT_STAGES];
    logic [31:0]            n_rem  [SQRT_STAGES];
    logic [30:0]            n_root [SQRT_STAGES];

    // one digit-by-digit step: bring down two bits, try root*4+1
    function automatic logic [62:0] root_step(input logic [31:0] rem,
                                              input logic [30:0] root,
                                              input logic [1:0]  bits);
        logic [33:0] cur;
        logic [33:0] t;
        logic [33:0] d;
        cur = {rem, bits};
        t   = {1'b0, root, 2'b01};
        d   = cur - t;
        if (cur >= t) begin
            return {d[31:0], root[29:0], 1'b1};
        end
        return {cur[31:0], root[29:0], 1'b0};
    endfunction

    always_comb begin
        {n_rem[0], n_root[0]} = root_step('0, '0, i_data.s[61:60]);
        for (int k = 1; k < SQRT_STAGES; k++) begin
            {n_rem[k], n_root[k]} = root_step(r_rem[k-1], r_root[k-1],
                                              r_pl[k-1].s[61-2*k -: 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl[0] <= i_data;
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                if (k > 0) begin
                    r_pl[k] <= r_pl[k-1];
                end
            end
        end
    end

    assign o_vld       = r_vld[SQRT_STAGES-1];
    assign o_data.side = r_pl[SQRT_STAGES-1].side;
    assign o_data.a    = r_pl[SQRT_STAGES-1].a;
    assign o_data.len  = r_root[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/vsn_div.sv =====
`default_nettype none
module vsn_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire vsn_pkg::t_div_in  i_data,
    output logic                   o_vld,
    output vsn_pkg::t_div_out      o_data
);
    import vsn_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [45:0]           r_rem [DIV_STAGES][3];
    logic [14:0]           r_q   [DIV_STAGES][3];
    t_div_in               r_pl  [DIV_STAGES];
    logic [45:0]           n_rem [DIV_STAGES][3];
    logic [14:0]           n_q   [DIV_STAGES][3];

    // restoring step against len shifted to quotient bit sh
    function automatic logic [46:0] div_step(input logic [45:0] rem,
                                             input logic [30:0] len,
                                             input int          sh);
        logic [45:0] d;
        d = 46'(len) << sh;
        if (rem >= d) begin
            return {rem - d, 1'b1};
        end
        return {rem, 1'b0};
    endfunction

    always_comb begin
        logic [45:0] num;
        logic        qb;
        for (int i = 0; i < 3; i++) begin
            // a*2^14 plus half the length gives rounding to nearest
            num = {2'b00, i_data.a[i], 14'd0} + {16'd0, i_data.len[30:1]};
            {n_rem[0][i], qb} = div_step(num, i_data.len, DIV_STAGES-1);
            n_q[0][i] = {14'd0, qb};
            for (int k = 1; k < DIV_STAGES; k++) begin
                {n_rem[k][i], qb} = div_step(r_rem[k-1][i], r_pl[k-1].len,
                                             DIV_STAGES-1-k);
                n_q[k][i] = {r_q[k-1][i][13:0], qb};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl[0] <= i_data;
            for (int k = 0; k < DIV_STAGES; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[k][i] <= n_rem[k][i];
                    r_q[k][i]   <= n_q[k][i];
                end
                if (k > 0) begin
                    r_pl[k] <= r_pl[k-1];
                end
            end
        end
    end

    assign o_vld       = r_vld[DIV_STAGES-1];
    assign o_data.side = r_pl[DIV_STAGES-1].side;
    assign o_data.q    = {r_q[DIV_STAGES-1][2], r_q[DIV_STAGES-1][1], r_q[DIV_STAGES-1][0]};

endmodule
`default_nettype wire

// ===== rtl/core/vertex_scale_normal_renorm.sv =====
// Pipeline from input word to output word: 7 front stages, 31 square root,
// 15 divide, 1 output register.
// Throughput: one vertex per clock; the whole pipeline advances together and
// holds only when the output register is full and not taken.
// Reset (synchronous, active low) empties the pipeline and sets each scale to 1.0.
`default_nettype none
module vertex_scale_normal_renorm (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave stream: tdata = pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z (from bit 0)
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [143:0] i_s_tdata,
    // master stream: tdata = out_pos_x/y/z, out_nrm_x/y/z (from bit 0)
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [143:0]      o_m_tdata,
    // tuser = degenerate
    output logic [0:0]        o_m_tuser,
    // APB configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import vsn_pkg::*;

    logic [2:0][23:0] r_scale;
    logic             en;
    logic             f_vld, s_vld, d_vld;
    t_root_in         f_data;
    t_div_in          s_data;
    t_div_out         d_data;
    logic             r_out_vld;
    logic [143:0]     r_out_data;
    logic             r_out_deg;
    logic [143:0]     n_out_data;

    // ---- configuration registers ----
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= {SCALE_ONE, SCALE_ONE, SCALE_ONE};
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_SCALE_X: r_scale[0] <= pwdata[23:0];
                REG_SCALE_Y: r_scale[1] <= pwdata[23:0];
                REG_SCALE_Z: r_scale[2] <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCALE_X: prdata = {8'd0, r_scale[0]};
            REG_SCALE_Y: prdata = {8'd0, r_scale[1]};
            REG_SCALE_Z: prdata = {8'd0, r_scale[2]};
            default:     prdata = '0;
        endcase
    end

    // ---- pipeline advance: moves unless the output word is stuck ----
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    // products, rounding, abs, max, leading one, normalize, squares, sum
    vsn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_pos   (i_s_tdata[95:0]),
        .i_nrm   (i_s_tdata[143:96]),
        .i_scale (r_scale),
        .o_vld   (f_vld),
        .o_data  (f_data)
    );

    // vector length
    vsn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_data  (f_data),
        .o_vld   (s_vld),
        .o_data  (s_data)
    );

    // three rounded divides by the length, one lane per axis
    vsn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_data  (s_data),
        .o_vld   (d_vld),
        .o_data  (d_data)
    );

    // ---- sign restore and output register ----
    always_comb begin
        logic [15:0] q;
        n_out_data[95:0] = d_data.side.pos;
        for (int i = 0; i < 3; i++) begin
            q = {1'b0, d_data.q[i]};
            if (d_data.side.deg) begin
                q = '0;     // zero-length normal gives a zero normal
            end else if (d_data.side.neg[i]) begin
                q = -q;
            end
            n_out_data[96 + 16*i +: 16] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_deg  <= d_data.side.deg;
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_deg;

endmodule
`default_nettype wire

// ===== test/vertex_scale_normal_renorm_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Checker: predicts the scaled position, unit normal and degenerate flag for each
// vertex word taken in, and holds the predictions in arrival order.
class vertex_scoreboard;
    logic [143:0] want_data[$];
    logic         want_deg[$];
    int           errors;
    logic [23:0]  scale[3];

    function new();
        errors = 0;
        scale[0] = vsn_pkg::SCALE_ONE;
        scale[1] = vsn_pkg::SCALE_ONE;
        scale[2] = vsn_pkg::SCALE_ONE;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Round to nearest (ties up), then clamp to 32 bits.
    function automatic logic [31:0] scaled_pos(logic signed [31:0] p, logic signed [23:0] sc);
        logic signed [63:0] prod;
        logic signed [63:0] r;
        prod = 64'(p) * 64'(sc);
        r = (prod + 64'sd32768) >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function void note_vertex(logic [143:0] d);
        logic [143:0]       res;
        logic signed [63:0] m[3];
        logic [63:0]        a[3];
        logic [63:0]        mx;
        logic [63:0]        s;
        logic [63:0]        len;
        logic [63:0]        q;
        int                 p;
        res = '0;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            res[32*i +: 32] = scaled_pos(d[32*i +: 32], scale[i]);
            m[i] = 64'($signed(d[96 + 16*i +: 16])) * 64'($signed(scale[i]));
            a[i] = (m[i] < 0) ? 64'(-m[i]) : 64'(m[i]);
            if (a[i] > mx) mx = a[i];
        end
        if (mx == 0) begin
            want_data.push_back(res);
            want_deg.push_back(1'b1);
            return;
        end
        p = 0;
        while (p < 63 && (mx >> (p + 1)) != 0) p++;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (p > 29) a[i] = a[i] >> (p - 29);
            else a[i] = a[i] << (29 - p);
            s = s + a[i] * a[i];
        end
        len = root64(s);
        for (int i = 0; i < 3; i++) begin
            q = (a[i] * 64'd16384 + (len >> 1)) / len;
            if (m[i] < 0) q = -q;
            res[96 + 16*i +: 16] = q[15:0];
        end
        want_data.push_back(res);
        want_deg.push_back(1'b0);
    endfunction

    function void report(string what);
        errors++;
        $display("mismatch: %s", what);
    endfunction

    function void check_result(logic [143:0] d, logic deg);
        logic [143:0] w;
        logic         wd;
        if (want_data.size() == 0) begin
            report("output word with nothing pending");
            return;
        end
        w = want_data.pop_front();
        wd = want_deg.pop_front();
        for (int i = 0; i < 3; i++) begin
            if (d[32*i +: 32] !== w[32*i +: 32])
                report($sformatf("pos[%0d] got %h want %h", i, d[32*i +: 32], w[32*i +: 32]));
            if (d[96 + 16*i +: 16] !== w[96 + 16*i +: 16])
                report($sformatf("nrm[%0d] got %h want %h", i, d[96 + 16*i +: 16],
                    w[96 + 16*i +: 16]));
        end
        if (deg !== wd) report($sformatf("degenerate got %b want %b", deg, wd));
    endfunction
endclass

module vertex_scale_normal_renorm_test;
    import vsn_pkg::*;

    localparam int LATENCY = 54;
    localparam int LIMIT   = 400000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [143:0] o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    vertex_scoreboard board;
    logic quiet;      // no idling in the closing part
    logic hold_off;   // long receiver stall request
    int   cycles;

    always #4 i_clk = ~i_clk;

    vertex_scale_normal_renorm dut (.*);

    initial board = new();

    // Checks outputs and notes inputs at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) board.note_vertex(i_s_tdata);
            if (o_m_tvalid && i_m_tready) board.check_result(o_m_tdata, o_m_tuser[0]);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off to fill the pipe.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_m_tready <= 0;
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                i_m_tready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("FAIL vertex_scale_normal_renorm");
                $finish;
            end
        end
    end

    task automatic write_scale(logic [1:0] idx, logic [23:0] v);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= {8'h00, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.scale[idx] = v;
    endtask

    // Offer one vertex word; keeps tvalid high if another follows at once.
    task automatic send_vertex(logic [143:0] d);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 10);
            i_s_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (board.want_data.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [143:0] vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
        return {nz, ny, nx, z, y, x};
    endfunction

    function automatic logic [143:0] random_vertex();
        logic [143:0] d;
        for (int i = 0; i < 4; i++) d[32*i +: 32] = $urandom;
        d[143:128] = 16'($urandom);
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 5))
                0: d[96 + 16*i +: 16] = 16'h0000;
                1: d[96 + 16*i +: 16] = 16'h8000;
                2: d[96 + 16*i +: 16] = 16'(16'($urandom_range(0, 8)) - 16'd4);
                default: ;
            endcase
        end
        return d;
    endfunction

    function automatic logic [23:0] random_scale();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'h000000;
            3: return 24'(24'($urandom_range(0, 6)) - 24'd3);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        quiet = 0;
        hold_off = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset scales of 1.0
        send_vertex(vertex(32'h7fffffff, 32'h80000000, 32'h0, 16'h7fff, 16'h8000, 16'h0));
        send_vertex(vertex(32'h00010000, 32'hffff0000, 32'h1, 16'h0, 16'h0, 16'h0));
        send_vertex(vertex(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0));
        send_vertex(vertex(32'hffffffff, 32'h8000, 32'hffff8000, 16'h1, 16'hffff, 16'h1));
        send_vertex(vertex(32'h12345678, 32'h9abcdef0, 32'h0, 16'h8000, 16'h8000, 16'h8000));
        drain();

        // Directed: extreme scales, saturation and zero-scale degenerate cases
        write_scale(REG_SCALE_X, 24'h7fffff);
        write_scale(REG_SCALE_Y, 24'h800000);
        write_scale(REG_SCALE_Z, 24'h000000);
        send_vertex(vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_vertex(vertex(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000));
        send_vertex(vertex(32'h1, 32'hffffffff, 32'h5, 16'h0, 16'h0, 16'h7fff));
        send_vertex(vertex(32'h8000, 32'h8000, 32'h8000, 16'h1, 16'h0, 16'h1));
        drain();
        write_scale(REG_SCALE_X, 24'h000000);
        write_scale(REG_SCALE_Y, 24'h000000);
        write_scale(REG_SCALE_Z, 24'h000001);
        send_vertex(vertex(32'h7fffffff, 32'h1, 32'h00008000, 16'h7fff, 16'h7fff, 16'h0));
        send_vertex(vertex(32'h3, 32'h3, 32'hffff8000, 16'h1234, 16'h4321, 16'hffff));
        drain();

        // Random phases, each with new scales; long receiver hold-off in the first
        for (int ph = 0; ph < 8; ph++) begin
            write_scale(REG_SCALE_X, random_scale());
            write_scale(REG_SCALE_Y, random_scale());
            write_scale(REG_SCALE_Z, random_scale());
            if (ph == 0) hold_off = 1;
            if (ph == 7) quiet = 1;
            for (int k = 0; k < 200; k++) send_vertex(random_vertex());
            drain();
        end

        if (board.errors == 0) begin
            $display("PASS vertex_scale_normal_renorm");
        end else begin
            $display("FAIL vertex_scale_normal_renorm");
        end
        $finish;
    end
endmodule

`default_nettype wire
